@@ hdl/msr_pkg.sv @@
// Shared types, constants and CRC helper for the sensor read responder.
`default_nettype none
package msr_pkg;

  localparam int FRAME_BYTES    = 8;
  localparam int IDX_W          = $clog2(FRAME_BYTES);
  localparam int CRC_BYTES      = 6;
  localparam int SAMPLE_W       = 10;
  localparam int AVG_FRAC_BITS  = 16;
  localparam int AVG_W          = SAMPLE_W + AVG_FRAC_BITS;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int PROD_W         = GAIN_W + AVG_W;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [15:0] WANT_COUNT = 16'h0001;

  localparam logic [7:0]  RST_SLAVE_ADDRESS   = 8'd2;
  localparam logic [15:0] RST_SMOOTHING_GAIN  = 16'd6554;
  localparam logic [7:0]  RST_REGISTER_NUMBER = 8'd0;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
    logic [7:0]          rx_byte;
  } msr_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } msr_out_t;

  typedef struct packed {
    logic [7:0]        slave_address;
    logic [GAIN_W-1:0] smoothing_gain;
    logic [7:0]        register_number;
  } msr_cfg_t;

  typedef enum logic [1:0] {
    REG_SLAVE_ADDRESS,
    REG_SMOOTHING_GAIN,
    REG_REGISTER_NUMBER
  } msr_reg_t;

  typedef enum logic {
    ITEM_SAMPLE,
    ITEM_BYTE
  } msr_kind_t;

  typedef struct packed {
    msr_kind_t           kind;
    logic [SAMPLE_W-1:0] data;
  } msr_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_UPD,
    B_CRC,
    B_CHECK,
    B_SEND
  } msr_state_t;

  // Fold one byte into a reflected CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/msr_cfg.sv @@
// APB-style register file for address, gain and register number.
`default_nettype none
module msr_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [msr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [msr_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output msr_pkg::msr_cfg_t                  cfg
);

  msr_pkg::msr_cfg_t cfg_r;
  msr_pkg::msr_cfg_t cfg_nxt;
  msr_pkg::msr_reg_t sel;
  logic              wr;

  assign sel    = msr_pkg::msr_reg_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (sel)
        msr_pkg::REG_SLAVE_ADDRESS:   cfg_nxt.slave_address   = pwdata[7:0];
        msr_pkg::REG_SMOOTHING_GAIN:  cfg_nxt.smoothing_gain  = pwdata[msr_pkg::GAIN_W-1:0];
        msr_pkg::REG_REGISTER_NUMBER: cfg_nxt.register_number = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      msr_pkg::REG_SLAVE_ADDRESS:   prdata = msr_pkg::PDATA_W'(cfg_r.slave_address);
      msr_pkg::REG_SMOOTHING_GAIN:  prdata = msr_pkg::PDATA_W'(cfg_r.smoothing_gain);
      msr_pkg::REG_REGISTER_NUMBER: prdata = msr_pkg::PDATA_W'(cfg_r.register_number);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address   <= msr_pkg::RST_SLAVE_ADDRESS;
      cfg_r.smoothing_gain  <= msr_pkg::RST_SMOOTHING_GAIN;
      cfg_r.register_number <= msr_pkg::RST_REGISTER_NUMBER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/msr_front.sv @@
// Input side: accept items and classify them into sample or byte work.
`default_nettype none
module msr_front (
  input  wire logic               push,
  output logic                    full,
  input  wire msr_pkg::msr_in_t   in_data,
  output logic                    q_wr,
  output msr_pkg::msr_item_t      q_item,
  input  wire logic               q_full
);

  assign full = q_full;
  assign q_wr = push & ~q_full;

  // Keep only the field that the command uses.
  always_comb begin
    if (in_data.command) begin
      q_item.kind = msr_pkg::ITEM_BYTE;
      q_item.data = msr_pkg::SAMPLE_W'(in_data.rx_byte);
    end else begin
      q_item.kind = msr_pkg::ITEM_SAMPLE;
      q_item.data = in_data.sample;
    end
  end

endmodule
`default_nettype wire

@@ hdl/msr_queue.sv @@
// Short work queue between the front and back parts.
`default_nettype none
module msr_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire msr_pkg::msr_item_t  wr_item,
  output logic                     full,
  input  wire logic                rd_en,
  output msr_pkg::msr_item_t       rd_item,
  output logic                     empty
);

  msr_pkg::msr_item_t            mem_r [msr_pkg::QUEUE_DEPTH];
  logic [msr_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [msr_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [msr_pkg::QPTR_W:0]      count_r, count_nxt;
  logic                          do_wr, do_rd;

  assign full    = (count_r == (msr_pkg::QPTR_W+1)'(msr_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/msr_back.sv @@
// Back part: average update, frame gathering, CRC check and reply transmit.
`default_nettype none
module msr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire msr_pkg::msr_cfg_t   cfg,
  input  wire logic                q_empty,
  input  wire msr_pkg::msr_item_t  q_item,
  output logic                     q_rd,
  output logic                     empty,
  input  wire logic                pop,
  output msr_pkg::msr_out_t        out_data
);

  localparam logic [msr_pkg::IDX_W-1:0] LAST_IDX     = msr_pkg::IDX_W'(msr_pkg::FRAME_BYTES-1);
  localparam logic [msr_pkg::IDX_W-1:0] LAST_CRC_IDX = msr_pkg::IDX_W'(msr_pkg::CRC_BYTES-1);
  localparam logic [msr_pkg::AVG_W-1:0] AVG_MAX      = '1;

  msr_pkg::msr_state_t             state_r, state_nxt;
  logic [msr_pkg::AVG_W-1:0]       avg_r, avg_nxt;
  logic [msr_pkg::AVG_W-1:0]       diff_r, diff_nxt;
  logic                            up_r, up_nxt;
  logic [msr_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic [7:0]                      frame_r [msr_pkg::FRAME_BYTES];
  logic                            frame_we;
  logic [msr_pkg::IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [msr_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [15:0]                     crc_req_r, crc_req_nxt;
  logic [15:0]                     crc_rep_r, crc_rep_nxt;
  logic                            out_valid_r, out_valid_nxt;
  msr_pkg::msr_out_t               out_r, out_nxt;

  logic [msr_pkg::AVG_W-1:0]       target;
  logic [msr_pkg::AVG_W-1:0]       step;
  logic [msr_pkg::AVG_W:0]         sum;
  logic [msr_pkg::SAMPLE_W-1:0]    avg_int;
  logic [7:0]                      frame_byte;
  logic [7:0]                      rep_byte;
  logic                            slot_free;
  logic                            req_ok;

  assign empty     = ~out_valid_r;
  assign out_data  = out_r;
  assign slot_free = ~out_valid_r | pop;
  assign avg_int   = avg_r[msr_pkg::AVG_FRAC_BITS +: msr_pkg::SAMPLE_W];
  assign target    = {q_item.data, {msr_pkg::AVG_FRAC_BITS{1'b0}}};
  assign step      = prod_r[msr_pkg::GAIN_FRAC_BITS +: msr_pkg::AVG_W];
  assign sum       = {1'b0, avg_r} + {1'b0, step};
  assign frame_byte = frame_r[idx_r];

  // Reply byte at the shared index: header copy, average, then fresh CRC.
  always_comb begin
    case (idx_r)
      3'd4:    rep_byte = 8'(avg_int >> 8);
      3'd5:    rep_byte = avg_int[7:0];
      3'd6:    rep_byte = crc_rep_r[15:8];
      3'd7:    rep_byte = crc_rep_r[7:0];
      default: rep_byte = frame_byte;
    endcase
  end

  assign req_ok = (frame_r[0] == cfg.slave_address) &&
                  (frame_r[1] == msr_pkg::FUNC_READ) &&
                  (frame_r[3] == cfg.register_number) &&
                  (frame_r[5] == msr_pkg::WANT_COUNT[7:0]) &&
                  (frame_r[6] == crc_req_r[15:8]) &&
                  (frame_r[7] == crc_req_r[7:0]);

  always_comb begin
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    diff_nxt      = diff_r;
    up_nxt        = up_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    crc_req_nxt   = crc_req_r;
    crc_rep_nxt   = crc_rep_r;
    out_valid_nxt = out_valid_r & ~pop;
    out_nxt       = out_r;
    frame_we      = 1'b0;
    q_rd          = 1'b0;
    case (state_r)
      msr_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          if (q_item.kind == msr_pkg::ITEM_SAMPLE) begin
            up_nxt    = (target >= avg_r);
            diff_nxt  = (target >= avg_r) ? target - avg_r : avg_r - target;
            state_nxt = msr_pkg::B_MUL;
          end else begin
            frame_we = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            if (cnt_r == LAST_IDX) begin
              idx_nxt     = '0;
              crc_req_nxt = msr_pkg::CRC_INIT;
              crc_rep_nxt = msr_pkg::CRC_INIT;
              state_nxt   = msr_pkg::B_CRC;
            end
          end
        end
      end
      msr_pkg::B_MUL: begin
        prod_nxt  = msr_pkg::PROD_W'(cfg.smoothing_gain) * msr_pkg::PROD_W'(diff_r);
        state_nxt = msr_pkg::B_UPD;
      end
      msr_pkg::B_UPD: begin
        if (up_r) begin
          avg_nxt = sum[msr_pkg::AVG_W] ? AVG_MAX : sum[msr_pkg::AVG_W-1:0];
        end else begin
          avg_nxt = (step > avg_r) ? '0 : avg_r - step;
        end
        state_nxt = msr_pkg::B_IDLE;
      end
      msr_pkg::B_CRC: begin
        // Request and reply CRCs advance together, one byte per cycle.
        crc_req_nxt = msr_pkg::crc_byte(crc_req_r, frame_byte);
        crc_rep_nxt = msr_pkg::crc_byte(crc_rep_r, rep_byte);
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == LAST_CRC_IDX) begin
          state_nxt = msr_pkg::B_CHECK;
        end
      end
      msr_pkg::B_CHECK: begin
        idx_nxt   = '0;
        state_nxt = req_ok ? msr_pkg::B_SEND : msr_pkg::B_IDLE;
      end
      msr_pkg::B_SEND: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt.tx_byte = rep_byte;
          out_nxt.last    = (idx_r == LAST_IDX);
          idx_nxt         = idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = msr_pkg::B_IDLE;
          end
        end
      end
      default: state_nxt = msr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_r[cnt_r] <= q_item.data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    diff_r    <= diff_nxt;
    up_r      <= up_nxt;
    prod_r    <= prod_nxt;
    idx_r     <= idx_nxt;
    crc_req_r <= crc_req_nxt;
    crc_rep_r <= crc_rep_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msr_pkg::B_IDLE;
      avg_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avg_r       <= avg_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/modbus_sensor_read_responder.sv @@
// Top level of the Modbus sensor read responder.
`default_nettype none
// Modbus RTU read-holding-register responder with a smoothed sensor value.
// Each input transfer is either a 10-bit converter sample (command 0) or one
// received request byte (command 1). Samples update an exponential moving
// average kept as unsigned 10.16 fixed point, step = gain * (sample - avg)
// with the gain in Q0.16, truncated toward zero and saturated. Bytes are
// gathered into 8-byte frames; a frame whose address, function code 3,
// register number, count low byte 1 and CRC-16 (reflected 0xA001, init
// 0xFFFF, compared high byte first) all match is answered with an 8-byte
// reply: request bytes 0-3, the integer part of the average high byte
// first, then a fresh CRC high byte first. Any other frame is dropped
// without output. Flow: a front stage takes transfers into a four-entry
// work queue, so push sees full only when four items wait. The back
// sequencer takes a request byte in its idle state and a sample through
// difference, multiply and update steps; on the eighth byte of a frame it
// runs the CRCs over six bytes, one byte per cycle for the request and
// reply CRCs in parallel, then a check state, then eight reply transfers,
// each paced by pop through a single output register. Configuration
// registers lie at byte addresses 0 (slave address), 4 (gain) and 8
// (register number); write them only while the block is idle.
module modbus_sensor_read_responder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel
  input  wire logic                         push,
  output logic                              full,
  input  wire msr_pkg::msr_in_t             in_data,
  // Result channel
  output logic                              empty,
  input  wire logic                         pop,
  output msr_pkg::msr_out_t                 out_data,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [msr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [msr_pkg::PDATA_W-1:0]  pwdata,
  output logic      [msr_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  msr_pkg::msr_cfg_t  cfg;
  msr_pkg::msr_item_t wr_item;
  msr_pkg::msr_item_t rd_item;
  logic               q_wr;
  logic               q_full;
  logic               q_rd;
  logic               q_empty;

  // Hold the three configuration registers.
  msr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Classify each accepted transfer as sample or byte work.
  msr_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_wr    (q_wr),
    .q_item  (wr_item),
    .q_full  (q_full)
  );

  // Decouple the input side from the back sequencer.
  msr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_item (wr_item),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  // Average, frame check and reply transmit, in arrival order.
  msr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_item   (rd_item),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
